// ----- rtl/adaptive_differential_quantizer_assert.svh -----
// assertion macros for the adaptive differential quantizer
`ifndef ADAPTIVE_DIFFERENTIAL_QUANTIZER_ASSERT_SVH
`define ADAPTIVE_DIFFERENTIAL_QUANTIZER_ASSERT_SVH

`ifndef SYNTHESIS

// combinational invariant checked at every clock edge out of reset
`define ADQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("adq assertion failed");

// same-cycle implication
`define ADQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adq implication failed");

// next-cycle implication
`define ADQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adq next-cycle implication failed");

`else

`define ADQ_ASSERT(lbl, clk, rst_n, prop)
`define ADQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ADQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/adq_pkg.sv -----
`default_nettype none

package adq_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 15;
    localparam int COEF_W       = 16;
    localparam int WLEN_W       = 5;
    localparam int LIMIT_W      = 15;
    localparam int STEP_W       = 15;
    localparam int SUM_W        = 20;
    localparam int MAG_W        = SAMPLE_W + 1;
    localparam int WINDOW_DEPTH = 16;
    localparam int SLOT_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int RING_W       = $clog2(WINDOW_DEPTH + 32);

    localparam int DIV_W        = SUM_W;
    localparam int DIV_CNT_W    = $clog2(DIV_W + 1);
    localparam int QUANT_ITER   = MAG_W;

    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;

    localparam logic [STEP_W-1:0] STEP_MAX = 15'd32766;
    localparam logic [STEP_W-1:0] STEP_MIN = 15'd1;

    localparam logic [1:0] REG_STEP_GAIN      = 2'd0;
    localparam logic [1:0] REG_PREDICTOR_COEF = 2'd1;
    localparam logic [1:0] REG_WINDOW_LENGTH  = 2'd2;
    localparam logic [1:0] REG_LEVEL_LIMIT    = 2'd3;

    typedef struct packed {
        logic [GAIN_W-1:0]        step_gain;
        logic signed [COEF_W-1:0] predictor_coef;
        logic [WLEN_W-1:0]        window_length;
        logic [LIMIT_W-1:0]       level_limit;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [STEP_W-1:0]    divisor;
        logic [DIV_CNT_W-1:0] count;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- rtl/adq_sample_if.sv -----
`default_nettype none

interface adq_sample_if;
    import adq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/adq_level_if.sv -----
`default_nettype none

interface adq_level_if;
    import adq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] level;

    modport source (output valid, output level, input ready);
    modport sink (input valid, input level, output ready);
endinterface

`default_nettype wire

// ----- rtl/adq_cfg.sv -----
`default_nettype none

module adq_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [adq_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [adq_pkg::PDATA_W-1:0]   pwdata,
    output logic      [adq_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    output adq_pkg::t_cfg                      o_cfg
);
    import adq_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_gain      <= 15'd16384;
            r_cfg.predictor_coef <= '0;
            r_cfg.window_length  <= 5'd10;
            r_cfg.level_limit    <= 15'd7;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_STEP_GAIN:      r_cfg.step_gain      <= pwdata[GAIN_W-1:0];
                REG_PREDICTOR_COEF: r_cfg.predictor_coef <= pwdata[COEF_W-1:0];
                REG_WINDOW_LENGTH:  r_cfg.window_length  <= pwdata[WLEN_W-1:0];
                REG_LEVEL_LIMIT:    r_cfg.level_limit    <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_STEP_GAIN:      prdata = PDATA_W'(r_cfg.step_gain);
            REG_PREDICTOR_COEF: prdata = PDATA_W'(unsigned'(r_cfg.predictor_coef));
            REG_WINDOW_LENGTH:  prdata = PDATA_W'(r_cfg.window_length);
            REG_LEVEL_LIMIT:    prdata = PDATA_W'(r_cfg.level_limit);
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/adq_div.sv -----
`default_nettype none

// restoring unsigned divider, one quotient bit per cycle
module adq_div (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  adq_pkg::t_div_req  i_req,
    output adq_pkg::t_div_rsp  o_rsp
);
    import adq_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [STEP_W-1:0]    r_dvs;
    logic [STEP_W-1:0]    r_rem;
    logic [DIV_W-1:0]     r_quo;

    logic [STEP_W:0]      trial;
    logic                 ge;
    logic [STEP_W:0]      diff;

    assign trial = {r_rem, r_quo[DIV_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder stays below the divisor, so it fits the divisor width
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvs <= i_req.divisor;
            r_rem <= '0;
            r_quo <= i_req.dividend;
        end else if (r_busy) begin
            r_rem <= ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

endmodule

`default_nettype wire

// ----- rtl/adaptive_differential_quantizer.sv -----
`default_nettype none

// Adaptive differential quantizer: each sample transaction yields one level transaction.
// The level is (sample - prediction) / step, truncated toward zero and clamped to
// -level_limit-1..level_limit; the block then rebuilds the sample, updates a first-order
// prediction and adapts the step from a 16-entry window of dequantized magnitudes.
// The block takes one sample at a time and accepts no new sample until the last one has
// passed the shared restoring divider, which runs 17 iterations for the quantizing divide
// and 20 for the step divide, and the five sequencing states between the divides (MDQ,
// REC, UPD, MSG and SDIV, three of them on the shared multiplier) and its level has been
// moved into the output register. With window_length zero the step divide is skipped
// and the step is set to STEP_MAX, the largest step value.
// The output register lets the next sample in while a level waits to be taken.
// Configuration through the APB port at byte addresses 0, 4, 8, 12; write only while idle.
module adaptive_differential_quantizer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    adq_sample_if.sink                         i_sample_ch,
    adq_level_if.source                        o_level_ch,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [adq_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [adq_pkg::PDATA_W-1:0]   pwdata,
    output logic      [adq_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready
);
    import adq_pkg::*;

`include "adaptive_differential_quantizer_assert.svh"

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_QDIV  = 4'd1;
    localparam logic [3:0] ST_QWAIT = 4'd2;
    localparam logic [3:0] ST_MDQ   = 4'd3;
    localparam logic [3:0] ST_REC   = 4'd4;
    localparam logic [3:0] ST_UPD   = 4'd5;
    localparam logic [3:0] ST_MSG   = 4'd6;
    localparam logic [3:0] ST_SDIV  = 4'd7;
    localparam logic [3:0] ST_SWAIT = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    localparam int MUL_A_W = SUM_W + 1;
    localparam int MUL_B_W = COEF_W;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [3:0]                  r_state;
    logic [3:0]                  n_state;

    logic signed [SAMPLE_W-1:0]  r_predicted;
    logic signed [SAMPLE_W-1:0]  r_last_rec;
    logic [STEP_W-1:0]           r_step;
    logic [SUM_W-1:0]            r_sum;
    logic [MAG_W-1:0]            r_window [WINDOW_DEPTH];
    logic [SLOT_W-1:0]           r_slot;
    logic                        r_out_valid;
    logic signed [SAMPLE_W-1:0]  r_out_level;

    logic signed [SAMPLE_W-1:0]  r_d;
    logic signed [SAMPLE_W-1:0]  r_level;
    logic signed [SAMPLE_W-1:0]  r_recon;
    logic [MAG_W-1:0]            r_mag;
    logic signed [PROD_W-1:0]    r_prod;

    logic                        in_acc;
    logic                        out_free;
    logic                        div_wait;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;

    logic [MAG_W-1:0]            d_ext;
    logic [MAG_W-1:0]            d_abs;
    logic signed [MAG_W:0]       q_signed;
    logic signed [MAG_W:0]       lim_hi;
    logic signed [MAG_W:0]       lim_lo;
    logic signed [SAMPLE_W-1:0]  level_clamped;

    logic signed [SAMPLE_W-1:0]  dq;
    logic [MAG_W-1:0]            dq_ext;
    logic [MAG_W-1:0]            dq_abs;

    logic signed [PROD_W-1:0]    coef_biased;
    logic [SAMPLE_W-1:0]         coef_term;

    logic [SUM_W-1:0]            sum_next;
    logic [RING_W-1:0]           ring;
    logic [RING_W-1:0]           slot_inc;
    logic [SUM_W-1:0]            p_val;
    logic [STEP_W-1:0]           step_clamped;

    adq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    adq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign i_sample_ch.ready = (r_state == ST_IDLE);
    assign in_acc            = i_sample_ch.valid & i_sample_ch.ready;
    assign o_level_ch.valid  = r_out_valid;
    assign o_level_ch.level  = r_out_level;
    assign out_free          = !r_out_valid || o_level_ch.ready;
    assign div_wait          = (r_state == ST_QWAIT) || (r_state == ST_SWAIT);

    // magnitude of the difference, 32768 kept unsigned
    assign d_ext = {r_d[SAMPLE_W-1], r_d};
    assign d_abs = r_d[SAMPLE_W-1] ? (MAG_W'(0) - d_ext) : d_ext;

    // signed quotient and clamp
    always_comb begin
        q_signed = r_d[SAMPLE_W-1] ? -$signed({1'b0, div_rsp.quotient[MAG_W-1:0]})
                                   : $signed({1'b0, div_rsp.quotient[MAG_W-1:0]});
        lim_hi   = $signed({{(MAG_W + 1 - LIMIT_W){1'b0}}, cfg.level_limit});
        lim_lo   = ~lim_hi;
        if (q_signed > lim_hi) begin
            level_clamped = lim_hi[SAMPLE_W-1:0];
        end else if (q_signed < lim_lo) begin
            level_clamped = lim_lo[SAMPLE_W-1:0];
        end else begin
            level_clamped = q_signed[SAMPLE_W-1:0];
        end
    end

    assign dq     = r_prod[SAMPLE_W-1:0];
    assign dq_ext = {dq[SAMPLE_W-1], dq};
    assign dq_abs = dq[SAMPLE_W-1] ? (MAG_W'(0) - dq_ext) : dq_ext;

    // coefficient product over 32768, truncated toward zero
    assign coef_biased = r_prod + (r_prod[PROD_W-1] ? PROD_W'(32767) : PROD_W'(0));
    assign coef_term   = coef_biased[SAMPLE_W+14:15];

    assign sum_next = r_sum - SUM_W'(r_window[r_slot]) + SUM_W'(r_mag);

    always_comb begin
        if (cfg.window_length == '0) begin
            ring = RING_W'(1);
        end else if (RING_W'(cfg.window_length) > RING_W'(WINDOW_DEPTH)) begin
            ring = RING_W'(WINDOW_DEPTH);
        end else begin
            ring = RING_W'(cfg.window_length);
        end
    end
    assign slot_inc = RING_W'(r_slot) + RING_W'(1);

    assign p_val = r_prod[SUM_W+14:15];

    always_comb begin
        if (div_rsp.quotient > DIV_W'(STEP_MAX)) begin
            step_clamped = STEP_MAX;
        end else if (div_rsp.quotient == '0) begin
            step_clamped = STEP_MIN;
        end else begin
            step_clamped = div_rsp.quotient[STEP_W-1:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_MDQ: begin
                mul_a = MUL_A_W'(r_level);
                mul_b = $signed({1'b0, r_step});
            end
            ST_REC: begin
                mul_a = MUL_A_W'(r_last_rec);
                mul_b = cfg.predictor_coef;
            end
            ST_MSG: begin
                mul_a = $signed({1'b0, r_sum});
                mul_b = $signed({1'b0, cfg.step_gain});
            end
            default: ;
        endcase
    end

    always_comb begin
        div_req          = '0;
        div_req.divisor  = r_step;
        div_req.dividend = {d_abs, {(DIV_W - MAG_W){1'b0}}};
        div_req.count    = DIV_CNT_W'(QUANT_ITER);
        if (r_state == ST_QDIV) begin
            div_req.start = 1'b1;
        end else if (r_state == ST_SDIV) begin
            div_req.dividend = p_val;
            div_req.divisor  = STEP_W'(cfg.window_length);
            div_req.count    = DIV_CNT_W'(DIV_W);
            div_req.start    = (cfg.window_length != '0);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (in_acc) n_state = ST_QDIV;
            ST_QDIV:  n_state = ST_QWAIT;
            ST_QWAIT: if (div_rsp.done) n_state = ST_MDQ;
            ST_MDQ:   n_state = ST_REC;
            ST_REC:   n_state = ST_UPD;
            ST_UPD:   n_state = ST_MSG;
            ST_MSG:   n_state = ST_SDIV;
            ST_SDIV:  n_state = (cfg.window_length == '0) ? ST_DONE : ST_SWAIT;
            ST_SWAIT: if (div_rsp.done) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_predicted <= '0;
            r_last_rec  <= '0;
            r_step      <= STEP_MIN;
            r_sum       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_window[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_level_ch.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_UPD: begin
                    r_predicted      <= r_recon - $signed(coef_term);
                    r_last_rec       <= r_recon;
                    r_sum            <= sum_next;
                    r_window[r_slot] <= r_mag;
                    r_slot           <= (slot_inc >= ring) ? '0 : slot_inc[SLOT_W-1:0];
                end
                ST_SDIV: begin
                    if (cfg.window_length == '0) begin
                        r_step <= STEP_MAX;
                    end
                end
                ST_SWAIT: begin
                    if (div_rsp.done) begin
                        r_step <= step_clamped;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_acc) begin
            r_d <= i_sample_ch.sample - r_predicted;
        end
        if (r_state == ST_QWAIT && div_rsp.done) begin
            r_level <= level_clamped;
        end
        if (r_state == ST_REC) begin
            r_recon <= dq + r_predicted;
            r_mag   <= dq_abs;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_level <= r_level;
        end
    end

    `ADQ_ASSERT(a_step_range, i_clk, i_rst_n, (r_step != '0) && (r_step != STEP_MAX + 15'd1))
    `ADQ_ASSERT_IMPL(a_div_done_waiting, i_clk, i_rst_n, div_rsp.done, div_wait)
    `ADQ_ASSERT_NEXT(a_accept_starts_div, i_clk, i_rst_n, in_acc, r_state == ST_QDIV)
    `ADQ_ASSERT(a_slot_in_ring, i_clk, i_rst_n, RING_W'(r_slot) < RING_W'(WINDOW_DEPTH))

endmodule

`default_nettype wire
